/* rtl/servo_gait_sequencer_assert.svh */
// Assertion macros for the servo gait sequencer.
// Used by the sequencer top level and its serial divider; no other dependencies.
`ifndef SERVO_GAIT_SEQUENCER_ASSERT_SVH
`define SERVO_GAIT_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define SGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sgs assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is held.
`define SGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sgs assertion failed: next-cycle implication");
`else
`define SGS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SGS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/sgs_pkg.sv */
// Shared types, constants and the gait table for the servo gait sequencer.
// No dependencies; imported by every other file but the assertion header and sgs_in_if.
`default_nettype none

package sgs_pkg;

  // Field widths fixed by the register map and the words on the channels.
  localparam int SPAN_W   = 9;
  localparam int HOLD_W   = 4;
  localparam int PULSE_W  = 12;
  localparam int POS_W    = 10;
  localparam int PHOUT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int NUM_SERVOS = 3;
  localparam int SIDX_W     = 2;

  // Serial divider: dividend is target minus position, divisor is hold plus one.
  localparam int DIV_W     = POS_W + 1;
  localparam int DVS_W     = HOLD_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Register reset values.
  localparam logic [SPAN_W-1:0]  LIFT_SPAN_RST    = 9'd350;
  localparam logic [SPAN_W-1:0]  TURN_SPAN_RST    = 9'd150;
  localparam logic [HOLD_W-1:0]  LIFT_HOLD_RST    = 4'd4;
  localparam logic [HOLD_W-1:0]  TURN_HOLD_RST    = 4'd4;
  localparam logic [PULSE_W-1:0] PULSE_CENTER_RST = 12'd1500;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIFT_SPAN    = 3'd0,
    REG_TURN_SPAN    = 3'd1,
    REG_LIFT_HOLD    = 3'd2,
    REG_TURN_HOLD    = 3'd3,
    REG_PULSE_CENTER = 3'd4
  } sgs_reg_idx_t;

  typedef struct packed {
    logic [SPAN_W-1:0]  lift_span;
    logic [SPAN_W-1:0]  turn_span;
    logic [HOLD_W-1:0]  lift_hold;
    logic [HOLD_W-1:0]  turn_hold;
    logic [PULSE_W-1:0] pulse_center;
  } sgs_cfg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } sgs_state_t;

  // Sign of a gait table entry.
  typedef enum logic [1:0] {
    SGN_ZERO,
    SGN_POS,
    SGN_NEG
  } sgs_sign_t;

  typedef struct packed {
    sgs_sign_t lift_sgn;
    sgs_sign_t turn_sgn;
    logic      use_lift_hold;
  } sgs_gait_t;

  typedef logic signed [POS_W-1:0] sgs_pos_t;

  // Divider handshake between the sequencer and the serial divider.
  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [DVS_W-1:0]        divisor;
  } sgs_div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quotient;
  } sgs_div_rsp_t;

  // Eight-entry gait table.
  function automatic sgs_gait_t sgs_gait_entry(input logic [PHOUT_W-1:0] pat);
    sgs_gait_t e;
    unique case (pat)
      3'd0: e = '{lift_sgn: SGN_POS,  turn_sgn: SGN_NEG,  use_lift_hold: 1'b1};
      3'd1: e = '{lift_sgn: SGN_POS,  turn_sgn: SGN_ZERO, use_lift_hold: 1'b0};
      3'd2: e = '{lift_sgn: SGN_POS,  turn_sgn: SGN_POS,  use_lift_hold: 1'b0};
      3'd3: e = '{lift_sgn: SGN_ZERO, turn_sgn: SGN_POS,  use_lift_hold: 1'b1};
      3'd4: e = '{lift_sgn: SGN_NEG,  turn_sgn: SGN_POS,  use_lift_hold: 1'b1};
      3'd5: e = '{lift_sgn: SGN_NEG,  turn_sgn: SGN_ZERO, use_lift_hold: 1'b0};
      3'd6: e = '{lift_sgn: SGN_NEG,  turn_sgn: SGN_NEG,  use_lift_hold: 1'b0};
      3'd7: e = '{lift_sgn: SGN_ZERO, turn_sgn: SGN_NEG,  use_lift_hold: 1'b1};
      default: e = '{lift_sgn: SGN_ZERO, turn_sgn: SGN_ZERO, use_lift_hold: 1'b0};
    endcase
    return e;
  endfunction

  // Apply a table sign to a span magnitude.
  function automatic sgs_pos_t sgs_signed_span(input sgs_sign_t sgn,
                                               input logic [SPAN_W-1:0] span);
    sgs_pos_t mag;
    mag = sgs_pos_t'({1'b0, span});
    unique case (sgn)
      SGN_POS: return mag;
      SGN_NEG: return -mag;
      default: return '0;
    endcase
  endfunction

  // Center plus position, saturated to the pulse field range.
  function automatic logic [PULSE_W-1:0] sgs_make_pulse(input logic [PULSE_W-1:0] center,
                                                        input sgs_pos_t pos);
    logic signed [PULSE_W+1:0] sum;
    sum = $signed({2'b00, center}) + (PULSE_W+2)'(pos);
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({2'b00, {PULSE_W{1'b1}}})) begin
      return {PULSE_W{1'b1}};
    end else begin
      return sum[PULSE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/sgs_in_if.sv */
// Input channel interface: one tick word with the two end-stop button levels.
// Has no dependencies; it does not import sgs_pkg.
`default_nettype none

interface sgs_in_if;
  logic valid;
  logic ready;
  logic min_pressed;
  logic max_pressed;

  modport source (output valid, output min_pressed, output max_pressed, input ready);
  modport sink   (input valid, input min_pressed, input max_pressed, output ready);
endinterface

`default_nettype wire

/* rtl/sgs_out_if.sv */
// Result channel interface: three pulse widths and the gait phase.
// Depends on sgs_pkg for the field widths.
`default_nettype none

interface sgs_out_if import sgs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_lift;
  logic [PULSE_W-1:0] pulse_turn_a;
  logic [PULSE_W-1:0] pulse_turn_b;
  logic [PHOUT_W-1:0] gait_phase;

  modport source (output valid, output pulse_lift, output pulse_turn_a,
                  output pulse_turn_b, output gait_phase, input ready);
  modport sink   (input valid, input pulse_lift, input pulse_turn_a,
                  input pulse_turn_b, input gait_phase, output ready);
endinterface

`default_nettype wire

/* rtl/sgs_cfg_if.sv */
// Configuration write channel interface: register index and write data.
// Depends on sgs_pkg for the field widths.
`default_nettype none

interface sgs_cfg_if import sgs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/servo_gait_sequencer.sv */
// Servo gait sequencer: one result word per tick, registered in the output register.
// The three servo updates share one bit-serial divider, one servo after another, so a new
// tick is taken only once the previous tick's result is loaded into the result register.
// A waiting result does not block the next tick's accept.
// Synchronous active-low reset restores the register defaults, phase 0, hold 0,
// and all positions and targets to zero.
`default_nettype none
`include "servo_gait_sequencer_assert.svh"

module servo_gait_sequencer import sgs_pkg::*; #(
  parameter int NUM_PHASES = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sgs_in_if.sink    in_ch,
  sgs_out_if.source out_ch,
  sgs_cfg_if.sink   cfg_ch
);

  localparam int PH_W = (NUM_PHASES > 2) ? $clog2(NUM_PHASES) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(NUM_PHASES - 1);
  localparam logic [SIDX_W-1:0] SIDX_LAST = SIDX_W'(NUM_SERVOS - 1);

  sgs_cfg_t     cfg;
  sgs_div_req_t div_req;
  sgs_div_rsp_t div_rsp;

  sgs_state_t        state_r, state_nxt;
  logic [PH_W-1:0]   phase_r;
  logic [HOLD_W-1:0] hold_r;
  logic [SIDX_W-1:0] sidx_r;
  sgs_pos_t          pos_r [NUM_SERVOS];
  sgs_pos_t          tgt_r [NUM_SERVOS];

  logic               out_valid_r;
  logic [PULSE_W-1:0] pulse_lift_r, pulse_turn_a_r, pulse_turn_b_r;
  logic [PHOUT_W-1:0] gait_phase_r;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic [PH_W-1:0]   phase_adv;
  sgs_gait_t         gait;
  sgs_pos_t          lift_tgt, turn_tgt;

  sgs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  sgs_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Phase advance and the gait table entry of the new phase.
  always_comb begin
    phase_adv = (phase_r == PH_LAST) ? '0 : phase_r + 1'b1;
    gait      = sgs_gait_entry(PHOUT_W'(phase_adv));
    lift_tgt  = sgs_signed_span(gait.lift_sgn, cfg.lift_span);
    turn_tgt  = sgs_signed_span(gait.turn_sgn, cfg.turn_span);
  end

  // Divider request for the servo in turn: (target - position) / (hold + 1).
  always_comb begin
    div_req.start    = (state_r == ST_START);
    div_req.dividend = DIV_W'(tgt_r[sidx_r]) - DIV_W'(pos_r[sidx_r]);
    div_req.divisor  = DVS_W'(hold_r) + 1'b1;
  end

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer next state and handshake outputs.
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    accept      = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          accept    = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (sidx_r == SIDX_LAST) ? ST_EMIT : ST_START;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Tick state: phase, hold count, targets, then one servo position per division.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      hold_r  <= '0;
      sidx_r  <= '0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        pos_r[i] <= '0;
        tgt_r[i] <= '0;
      end
    end else if (accept) begin
      sidx_r <= '0;
      if (hold_r == '0) begin
        phase_r  <= phase_adv;
        hold_r   <= gait.use_lift_hold ? cfg.lift_hold : cfg.turn_hold;
      end else begin
        hold_r   <= hold_r - 1'b1;
      end
      // The minimum button wins over the maximum button.
      priority if (in_ch.min_pressed) begin
        tgt_r[0] <= -sgs_pos_t'({1'b0, cfg.lift_span});
        tgt_r[1] <= -sgs_pos_t'({1'b0, cfg.turn_span});
        tgt_r[2] <= -sgs_pos_t'({1'b0, cfg.turn_span});
      end else if (in_ch.max_pressed) begin
        tgt_r[0] <= sgs_pos_t'({1'b0, cfg.lift_span});
        tgt_r[1] <= sgs_pos_t'({1'b0, cfg.turn_span});
        tgt_r[2] <= sgs_pos_t'({1'b0, cfg.turn_span});
      end else if (hold_r == '0) begin
        tgt_r[0] <= lift_tgt;
        tgt_r[1] <= turn_tgt;
        tgt_r[2] <= turn_tgt;
      end
    end else if (state_r == ST_WAIT && div_rsp.done) begin
      pos_r[sidx_r] <= pos_r[sidx_r] + POS_W'(div_rsp.quotient);
      sidx_r        <= sidx_r + 1'b1;
    end
  end

  // Output register, loaded once all three positions are updated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pulse_lift_r   <= sgs_make_pulse(cfg.pulse_center, pos_r[0]);
      pulse_turn_a_r <= sgs_make_pulse(cfg.pulse_center, pos_r[1]);
      pulse_turn_b_r <= sgs_make_pulse(cfg.pulse_center, pos_r[2]);
      gait_phase_r   <= PHOUT_W'(phase_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pulse_lift   = pulse_lift_r;
  assign out_ch.pulse_turn_a = pulse_turn_a_r;
  assign out_ch.pulse_turn_b = pulse_turn_b_r;
  assign out_ch.gait_phase   = gait_phase_r;

  `SGS_ASSERT_NXT(a_accept_starts, clk, rst_n, in_ch.valid && in_ch.ready, state_r == ST_START && sidx_r == '0)
  `SGS_ASSERT_IMP(a_done_in_wait, clk, rst_n, div_rsp.done, state_r == ST_WAIT)
  `SGS_ASSERT_NXT(a_emit_loads, clk, rst_n, state_r == ST_EMIT && out_free, out_valid_r && state_r == ST_IDLE)

endmodule

`default_nettype wire

/* rtl/sgs_cfg_regs.sv */
// Configuration register file for the servo gait sequencer.
// Depends on sgs_pkg and the sgs_cfg_if interface.
`default_nettype none

module sgs_cfg_regs import sgs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sgs_cfg_if.sink    cfg_ch,
  output sgs_cfg_t   cfg
);

  sgs_cfg_t cfg_r;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Register decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lift_span    <= LIFT_SPAN_RST;
      cfg_r.turn_span    <= TURN_SPAN_RST;
      cfg_r.lift_hold    <= LIFT_HOLD_RST;
      cfg_r.turn_hold    <= TURN_HOLD_RST;
      cfg_r.pulse_center <= PULSE_CENTER_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_LIFT_SPAN:    cfg_r.lift_span    <= cfg_ch.data[SPAN_W-1:0];
        REG_TURN_SPAN:    cfg_r.turn_span    <= cfg_ch.data[SPAN_W-1:0];
        REG_LIFT_HOLD:    cfg_r.lift_hold    <= cfg_ch.data[HOLD_W-1:0];
        REG_TURN_HOLD:    cfg_r.turn_hold    <= cfg_ch.data[HOLD_W-1:0];
        REG_PULSE_CENTER: cfg_r.pulse_center <= cfg_ch.data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/sgs_serial_div.sv */
// Bit-serial restoring divider, signed dividend by positive divisor, truncating.
// Depends on sgs_pkg and the assertion macro header.
`default_nettype none
`include "servo_gait_sequencer_assert.svh"

module sgs_serial_div import sgs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  sgs_div_req_t req,
  output sgs_div_rsp_t rsp
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     work_r;
  logic [DVS_W-2:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;

  logic [DVS_W-1:0]     shifted;
  logic                 fits;
  logic [DVS_W-2:0]     rem_nxt;
  logic [DIV_W-1:0]     dividend_mag;

  // One quotient bit per step: shift the next dividend bit into the remainder.
  always_comb begin
    shifted      = {rem_r, work_r[DIV_W-1]};
    fits         = (shifted >= dvs_r);
    rem_nxt      = fits ? (DVS_W-1)'(shifted - dvs_r) : (DVS_W-1)'(shifted);
    dividend_mag = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
  end

  // Control: busy for DIV_W steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out the top while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      work_r <= dividend_mag;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
      neg_r  <= req.dividend[DIV_W-1];
    end else if (busy_r) begin
      work_r <= {work_r[DIV_W-2:0], fits};
      rem_r  <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed(work_r) : $signed(work_r);

  `SGS_ASSERT_IMP(a_start_when_free, clk, rst_n, req.start, !busy_r)
  `SGS_ASSERT_NXT(a_done_after_last, clk, rst_n, busy_r && cnt_r == CNT_LAST && !req.start, done_r && !busy_r)
  `SGS_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_r, !busy_r)

endmodule

`default_nettype wire
